// ===== rtl/core/stream_term_search_capture_core_assert.svh =====
`ifndef STREAM_TERM_SEARCH_CAPTURE_CORE_ASSERT_SVH
`define STREAM_TERM_SEARCH_CAPTURE_CORE_ASSERT_SVH

// Condition that holds at every edge out of reset
`define STSC_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// Condition in one cycle implies a condition in the next
`define STSC_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Same-cycle implication
`define STSC_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`endif

// ===== rtl/core/stsc_pkg.sv =====
package stsc_pkg;

    localparam int TERM_W      = 64;
    localparam int LEN_W       = 4;
    localparam int STOP_W      = 32;
    localparam int STOP_CNT_W  = 3;
    localparam int STOP_SLOTS  = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEARCH_TERM     = 3'd0,
        REG_SEARCH_LENGTH   = 3'd1,
        REG_GIVEUP_TERM     = 3'd2,
        REG_GIVEUP_LENGTH   = 3'd3,
        REG_STOP_CHARS      = 3'd4,
        REG_STOP_CHAR_COUNT = 3'd5
    } cfg_reg_t;

    localparam logic OP_SCAN    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    function automatic logic [7:0] term_byte(input logic [TERM_W-1:0] term,
                                             input logic [2:0] idx);
        term_byte = term[idx*8 +: 8];
    endfunction

endpackage

// ===== rtl/core/stream_term_search_capture_core.sv =====
// Channel   Handshake              Payload
// --------  ---------------------  ---------------------------------------
// in        in_valid / in_stall    op, in_byte
// out       out_valid / out_stall  kind, result_byte
// cfg       cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; a result is registered in the
// input register, then in the result register, and is taken when out_stall is low.
// Search state advances as the item leaves the input register.
// in_stall rises only while the input register holds an item that has a
// result and the result register is full and stalled.
// Reset clears search state, configuration and both valid flags.
module stream_term_search_capture_core
    import stsc_pkg::*;
#(
    parameter int MAX_TERM_BYTES = 8,
    parameter int MAX_STOP_CHARS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [7:0]            in_byte,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [7:0]            result_byte
);

    localparam int POS_W    = $clog2(MAX_TERM_BYTES + 1);
    localparam int STOP_LIM = (MAX_STOP_CHARS < STOP_SLOTS) ? MAX_STOP_CHARS : STOP_SLOTS;

    logic [TERM_W-1:0]     search_term_reg;
    logic [LEN_W-1:0]      search_length_reg;
    logic [TERM_W-1:0]     giveup_term_reg;
    logic [LEN_W-1:0]      giveup_length_reg;
    logic [STOP_W-1:0]     stop_chars_reg;
    logic [STOP_CNT_W-1:0] stop_char_count_reg;

    logic                  s1_valid_reg;
    logic                  s1_op_reg;
    logic [7:0]            s1_byte_reg;

    logic [POS_W-1:0]      match_pos_reg, match_pos_next;
    logic [POS_W-1:0]      giveup_pos_reg, giveup_pos_next;
    logic                  done_reg, done_next;
    logic                  gave_up_reg, gave_up_next;

    logic                  out_valid_reg;
    logic                  kind_reg, kind_next;
    logic [7:0]            result_byte_reg;

    logic [POS_W-1:0]      slen;
    logic [POS_W-1:0]      glen;
    logic [STOP_CNT_W-1:0] stop_n;
    logic                  stop_hit;
    logic                  found;
    logic                  has_result;
    logic                  s1_move;
    logic                  in_load;
    logic                  giveup_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_term_reg     <= '0;
            search_length_reg   <= '0;
            giveup_term_reg     <= '0;
            giveup_length_reg   <= '0;
            stop_chars_reg      <= '0;
            stop_char_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SEARCH_TERM:     search_term_reg     <= cfg_data;
                REG_SEARCH_LENGTH:   search_length_reg   <= cfg_data[LEN_W-1:0];
                REG_GIVEUP_TERM:     giveup_term_reg     <= cfg_data;
                REG_GIVEUP_LENGTH:   giveup_length_reg   <= cfg_data[LEN_W-1:0];
                REG_STOP_CHARS:      stop_chars_reg      <= cfg_data[STOP_W-1:0];
                REG_STOP_CHAR_COUNT: stop_char_count_reg <= cfg_data[STOP_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        slen = (search_length_reg > LEN_W'(MAX_TERM_BYTES)) ?
               POS_W'(MAX_TERM_BYTES) : POS_W'(search_length_reg);
        glen = (giveup_length_reg > LEN_W'(MAX_TERM_BYTES)) ?
               POS_W'(MAX_TERM_BYTES) : POS_W'(giveup_length_reg);
        stop_n = (stop_char_count_reg > STOP_CNT_W'(STOP_LIM)) ?
                 STOP_CNT_W'(STOP_LIM) : stop_char_count_reg;

        stop_hit = 1'b0;
        for (int i = 0; i < STOP_SLOTS; i++)
        begin
            if ((STOP_CNT_W'(i) < stop_n) && (stop_chars_reg[i*8 +: 8] == s1_byte_reg))
                stop_hit = 1'b1;
        end

        found      = (match_pos_reg >= slen);
        has_result = (s1_op_reg == OP_SCAN) && !done_reg && !gave_up_reg && found;
        kind_next  = ((stop_char_count_reg == '0) || stop_hit) ? KIND_DONE : KIND_BYTE;

        s1_move  = s1_valid_reg && (!has_result || !out_valid_reg || !out_stall);
        in_stall = s1_valid_reg && !s1_move;
        in_load  = in_valid && !in_stall;

        match_pos_next  = match_pos_reg;
        giveup_pos_next = giveup_pos_reg;
        done_next       = done_reg;
        gave_up_next    = gave_up_reg;
        giveup_step     = 1'b0;

        priority if (s1_op_reg == OP_RESTART)
        begin
            match_pos_next  = '0;
            giveup_pos_next = '0;
            done_next       = 1'b0;
            gave_up_next    = 1'b0;
        end
        else if (done_reg || gave_up_reg)
        begin
            done_next = done_reg;
        end
        else if (found)
        begin
            done_next = (kind_next == KIND_DONE);
        end
        else
        begin
            if (s1_byte_reg == term_byte(search_term_reg, 3'(match_pos_reg)))
                match_pos_next = match_pos_reg + 1'b1;
            else
                match_pos_next = '0;

            if (glen != '0)
            begin
                giveup_step = (giveup_pos_reg < glen) &&
                    (s1_byte_reg == term_byte(giveup_term_reg, 3'(giveup_pos_reg)));
                giveup_pos_next = giveup_step ? giveup_pos_reg + 1'b1 : '0;
                gave_up_next    = (giveup_pos_next >= glen);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            match_pos_reg  <= '0;
            giveup_pos_reg <= '0;
            done_reg       <= 1'b0;
            gave_up_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_load)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
            begin
                match_pos_reg  <= match_pos_next;
                giveup_pos_reg <= giveup_pos_next;
                done_reg       <= done_next;
                gave_up_reg    <= gave_up_next;
            end

            if (s1_move && has_result)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            s1_op_reg   <= op;
            s1_byte_reg <= in_byte;
        end
        if (s1_move && has_result)
        begin
            kind_reg        <= kind_next;
            result_byte_reg <= s1_byte_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign result_byte = result_byte_reg;

`include "stream_term_search_capture_core_assert.svh"

    `STSC_ALWAYS(a_match_pos_range, match_pos_reg <= POS_W'(MAX_TERM_BYTES))
    `STSC_ALWAYS(a_giveup_pos_range, giveup_pos_reg <= POS_W'(MAX_TERM_BYTES))
    `STSC_NEXT(a_restart_clears, s1_move && (s1_op_reg == OP_RESTART),
               (match_pos_reg == '0) && (giveup_pos_reg == '0) && !done_reg && !gave_up_reg)
    `STSC_NEXT(a_done_after_marker, s1_move && has_result && (kind_next == KIND_DONE),
               done_reg && out_valid_reg && (kind_reg == KIND_DONE))
    `STSC_IMPL(a_no_result_when_halted, done_reg || gave_up_reg, !has_result)

endmodule

// ===== dv/tb_top.sv =====
module tb_top
    import stsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TERM_BYTES_MAX  = 8;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 105;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } capture_t;

    typedef struct {
        logic [TERM_W-1:0]     sterm;
        logic [LEN_W-1:0]      slen;
        logic [TERM_W-1:0]     gterm;
        logic [LEN_W-1:0]      glen;
        logic [STOP_W-1:0]     stops;
        logic [STOP_CNT_W-1:0] nstops;
    } search_setup_t;

    class capture_scoreboard;
        logic [TERM_W-1:0]     search_term;
        logic [LEN_W-1:0]      search_length;
        logic [TERM_W-1:0]     giveup_term;
        logic [LEN_W-1:0]      giveup_length;
        logic [STOP_W-1:0]     stop_chars;
        logic [STOP_CNT_W-1:0] stop_char_count;
        logic [3:0]            match_pos;
        logic [3:0]            giveup_pos;
        bit                    term_done;
        bit                    gave_up;
        capture_t              expected_captures[$];
        int                    errors;
        int                    items;
        int                    live_items;
        int                    captures;
        int                    completions;
        int                    setups;

        function new();
            search_term     = '0;
            search_length   = '0;
            giveup_term     = '0;
            giveup_length   = '0;
            stop_chars      = '0;
            stop_char_count = '0;
            clear_search();
            errors      = 0;
            items       = 0;
            live_items  = 0;
            captures    = 0;
            completions = 0;
            setups      = 0;
        endfunction

        function void clear_search();
            match_pos  = '0;
            giveup_pos = '0;
            term_done  = 1'b0;
            gave_up    = 1'b0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SEARCH_TERM:     search_term     = data;
                REG_SEARCH_LENGTH:   search_length   = data[LEN_W-1:0];
                REG_GIVEUP_TERM:     giveup_term     = data;
                REG_GIVEUP_LENGTH:   giveup_length   = data[LEN_W-1:0];
                REG_STOP_CHARS:      stop_chars      = data[STOP_W-1:0];
                REG_STOP_CHAR_COUNT: stop_char_count = data[STOP_CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit is_stop(logic [7:0] b);
            int n;
            n = (stop_char_count > STOP_SLOTS) ? STOP_SLOTS : int'(stop_char_count);
            for (int i = 0; i < n; i++)
                if (stop_chars[i*8 +: 8] == b)
                    return 1'b1;
            return 1'b0;
        endfunction

        function int pending();
            return expected_captures.size();
        endfunction

        function void note_input(logic item_op, logic [7:0] b);
            int       slen;
            int       glen;
            capture_t cap;
            slen = (search_length > TERM_BYTES_MAX) ? TERM_BYTES_MAX : int'(search_length);
            glen = (giveup_length > TERM_BYTES_MAX) ? TERM_BYTES_MAX : int'(giveup_length);
            items++;
            if (item_op == OP_RESTART) begin
                clear_search();
                live_items++;
                return;
            end
            if (term_done || gave_up)
                return;
            live_items++;
            if (match_pos >= slen) begin
                cap.data = b;
                if (stop_char_count == 0 || is_stop(b)) begin
                    cap.kind  = KIND_DONE;
                    term_done = 1'b1;
                end
                else
                    cap.kind = KIND_BYTE;
                expected_captures.push_back(cap);
                return;
            end
            if (b == search_term[int'(match_pos[2:0])*8 +: 8])
                match_pos = match_pos + 4'd1;
            else
                match_pos = '0;
            if (glen != 0) begin
                if (giveup_pos < glen && b == giveup_term[int'(giveup_pos[2:0])*8 +: 8])
                    giveup_pos = giveup_pos + 4'd1;
                else
                    giveup_pos = '0;
                if (giveup_pos >= glen)
                    gave_up = 1'b1;
            end
        endfunction

        function void check_result(logic k, logic [7:0] b);
            capture_t want;
            if (expected_captures.size() == 0) begin
                $error("result with nothing expected: kind %0d result_byte %02h", k, b);
                errors++;
                return;
            end
            want = expected_captures.pop_front();
            if (want.kind == KIND_DONE)
                completions++;
            else
                captures++;
            if (k !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, k);
                errors++;
            end
            if (b !== want.data) begin
                $error("result_byte: expected %02h, got %02h", want.data, b);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    logic [7:0]            in_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic                  kind;
    logic [7:0]            result_byte;

    capture_scoreboard sb;
    bit                gaps_on;
    bit                stall_on;

    stream_term_search_capture_core u_top (.*);

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && sb != null) begin
            if (in_valid && !in_stall)
                sb.note_input(op, in_byte);
            if (out_valid && !out_stall)
                sb.check_result(kind, result_byte);
        end
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'h41;
            4:       return 8'h42;
            5:       return 8'h43;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            hold = pick_gap();
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (stall_on && hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // hold the item until it is taken, then maybe idle
    task automatic send_item(logic item_op, logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        op       <= item_op;
        in_byte  <= b;
        do @(posedge clk); while (!(in_valid && !in_stall));
        gap = gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_setup(search_setup_t s);
        logic [63:0] junk;
        settle();
        junk = {$urandom, $urandom};
        write_reg(REG_SEARCH_TERM, s.sterm);
        write_reg(REG_SEARCH_LENGTH, {junk[63:LEN_W], s.slen});
        write_reg(REG_GIVEUP_TERM, s.gterm);
        write_reg(REG_GIVEUP_LENGTH, {junk[63:LEN_W], s.glen});
        write_reg(REG_STOP_CHARS, {junk[63:STOP_W], s.stops});
        write_reg(REG_STOP_CHAR_COUNT, {junk[63:STOP_CNT_W], s.nstops});
        cfg_we <= 1'b0;
        sb.setups++;
    endtask

    function automatic search_setup_t make_setup(logic [63:0] sterm, int slen,
                                                 logic [63:0] gterm, int glen,
                                                 logic [31:0] stops, int nstops);
        search_setup_t s;
        s.sterm  = sterm;
        s.slen   = LEN_W'(slen);
        s.gterm  = gterm;
        s.glen   = LEN_W'(glen);
        s.stops  = stops;
        s.nstops = STOP_CNT_W'(nstops);
        return s;
    endfunction

    function automatic search_setup_t random_setup(int phase);
        search_setup_t s;
        for (int i = 0; i < 8; i++) begin
            s.sterm[i*8 +: 8] = pick_byte();
            s.gterm[i*8 +: 8] = pick_byte();
        end
        for (int i = 0; i < 4; i++)
            s.stops[i*8 +: 8] = pick_byte();
        s.slen   = LEN_W'($urandom_range(0, 8));
        s.glen   = ($urandom_range(0, 2) == 0) ? '0 : LEN_W'($urandom_range(2, 8));
        s.nstops = STOP_CNT_W'($urandom_range(0, 4));
        case (phase)
            0: begin s.slen = 4'd8;  s.glen = 4'd8;  s.nstops = 3'd4; end
            1: begin s.slen = 4'd15; s.glen = 4'd15; s.nstops = 3'd7; end
            2: begin s.slen = 4'd0;  s.glen = 4'd0;  s.nstops = 3'd0; end
            3: begin
                s.slen   = LEN_W'($urandom_range(9, 14));
                s.glen   = 4'd1;
                s.nstops = STOP_CNT_W'($urandom_range(5, 6));
            end
            default: ;
        endcase
        return s;
    endfunction

    // maybe a restart, noise, maybe the give-up term, the term (at times broken), captured bytes, a stop byte, noise
    task automatic run_episode(search_setup_t s);
        int         slen;
        int         glen;
        int         nst;
        logic [7:0] b;
        slen = (s.slen > TERM_BYTES_MAX) ? TERM_BYTES_MAX : int'(s.slen);
        glen = (s.glen > TERM_BYTES_MAX) ? TERM_BYTES_MAX : int'(s.glen);
        nst  = (s.nstops > STOP_SLOTS) ? STOP_SLOTS : int'(s.nstops);
        if ($urandom_range(0, 99) < 85)
            send_item(OP_RESTART, 8'($urandom));
        repeat ($urandom_range(0, 3)) send_item(OP_SCAN, pick_byte());
        if (glen != 0 && $urandom_range(0, 99) < 20)
            for (int i = 0; i < glen; i++)
                send_item(OP_SCAN, s.gterm[i*8 +: 8]);
        for (int i = 0; i < slen; i++) begin
            b = s.sterm[i*8 +: 8];
            if ($urandom_range(0, 99) < 4)
                b = pick_byte();
            send_item(OP_SCAN, b);
        end
        repeat ($urandom_range(0, 6))
            send_item(OP_SCAN, ($urandom_range(0, 3) == 0) ? pick_byte() : 8'($urandom));
        if (nst != 0)
            send_item(OP_SCAN, s.stops[int'($urandom_range(0, nst - 1))*8 +: 8]);
        else
            send_item(OP_SCAN, 8'($urandom));
        repeat ($urandom_range(0, 2)) send_item(OP_SCAN, pick_byte());
    endtask

    initial begin
        search_setup_t s;
        int            target;
        int            drain_at;
        bit            drained;
        sb        = new();
        gaps_on   = 1'b0;
        stall_on  = 1'b0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_SEARCH_TERM;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        op        <= OP_SCAN;
        in_byte   <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        s = make_setup(64'h4241, 2, 64'h0, 0, 32'h2C3B, 2);
        apply_setup(s);
        send_item(OP_SCAN, 8'h41);
        send_item(OP_SCAN, 8'h58);
        send_item(OP_SCAN, 8'h42);
        send_item(OP_SCAN, 8'h41);
        send_item(OP_SCAN, 8'h41);
        send_item(OP_SCAN, 8'h42);
        send_item(OP_SCAN, 8'h41);
        send_item(OP_SCAN, 8'h42);
        send_item(OP_SCAN, 8'h00);
        send_item(OP_SCAN, 8'hFF);
        send_item(OP_SCAN, 8'h2C);
        send_item(OP_SCAN, 8'h5A);
        send_item(OP_RESTART, 8'hFF);

        s = make_setup(64'h0, 0, 64'h0, 0, 32'h0, 0);
        apply_setup(s);
        send_item(OP_SCAN, 8'h7E);
        send_item(OP_RESTART, 8'h00);

        s = make_setup(64'h4241, 2, 64'h42, 1, 32'h3B, 1);
        apply_setup(s);
        send_item(OP_SCAN, 8'h41);
        send_item(OP_SCAN, 8'h42);
        send_item(OP_SCAN, 8'h33);
        s.glen = '0;
        apply_setup(s);
        send_item(OP_SCAN, 8'h41);
        send_item(OP_RESTART, 8'h80);

        s = make_setup(64'h44434241, 4, 64'h0, 0, 32'hFF, 7);
        apply_setup(s);
        send_item(OP_SCAN, 8'h41);
        send_item(OP_SCAN, 8'h42);
        s.slen = 4'd2;
        apply_setup(s);
        send_item(OP_SCAN, 8'h80);
        send_item(OP_SCAN, 8'hFF);
        send_item(OP_RESTART, 8'h01);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            s = random_setup(p);
            apply_setup(s);
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            target   = sb.items + ITEMS_PER_PHASE;
            drain_at = sb.items + int'($urandom_range(10, ITEMS_PER_PHASE - 10));
            drained  = 1'b0;
            while (sb.items < target) begin
                run_episode(s);
                if (!drained && sb.items >= drain_at) begin
                    settle();
                    drained = 1'b1;
                end
            end
        end

        settle();
        $display("Ran %0d items (%0d not ignored) over %0d register setups.",
                 sb.items, sb.live_items, sb.setups);
        $display("Checked %0d captured bytes and %0d completion markers.",
                 sb.captures, sb.completions);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
